// ----- design/ffea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ffea_pkg;

   localparam int POOL_BLOCKS = 256;
   localparam int MAX_EXTENTS = 128;
   localparam int ADDR_W      = $clog2(MAX_EXTENTS);
   localparam int CNT_W       = ADDR_W + 1;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_A_RD,
      S_A_EVAL,
      S_R_RD,
      S_R_WR,
      S_F_RD,
      S_F_EVAL,
      S_F_DEC,
      S_I_RD,
      S_I_WR
   } state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_IDX,
      RD_IDX_P1,
      RD_IDX_M1
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_TRIM,
      WR_COPY,
      WR_MERGE_BOTH,
      WR_MERGE_LO,
      WR_MERGE_HI,
      WR_INSERT
   } wr_sel_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_INC,
      IDX_DEC,
      IDX_CNT
   } idx_op_type;

   typedef struct packed {
      logic       init;
      logic       load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      idx_op_type idx_op;
      logic       save_prev;
      logic       save_p;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       res_set;
      logic [1:0] res_status;
      logic       res_grant;
   } cmd_type;

   typedef struct packed {
      logic op_free;
      logic n_zero;
      logic free_skip;
      logic idx_lt_cnt;
      logic idx_p1_lt_cnt;
      logic idx_gt_p;
      logic fits;
      logic exact;
      logic below;
      logic lo;
      logic hi;
      logic full;
      logic out_busy;
   } stat_type;

endpackage
`default_nettype wire

// ----- design/ffea_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ffea_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] start_index;
   logic [8:0] block_count;

   modport source (output valid, output op, output start_index, output block_count,
                   input ready);
   modport sink (input valid, input op, input start_index, input block_count,
                 output ready);
endinterface
`default_nettype wire

// ----- design/ffea_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ffea_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] alloc_start;

   modport source (output valid, output status, output alloc_start, input ready);
   modport sink (input valid, input status, input alloc_start, output ready);
endinterface
`default_nettype wire

// ----- design/ffea_csr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ffea_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/first_fit_extent_allocator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Modport  Payload
// req_ch   in   sink     op, start_index, block_count
// rsp_ch   out  source   status, alloc_start
// csr_ch   in   sink     data (mem_size)
//
// One item at a time: each extent scanned takes a read step and an evaluate step, and
// each entry shifted on a remove or insert takes a read step and a write step.
// The scan and shift walk the extent table memory one entry at a time.
// Reset (synchronous) and every mem_size write rebuild the table in the S_INIT state.
// A pending result in the output register holds off the next item only until taken.
// A mem_size write is taken only while the controller is idle between items.
module first_fit_extent_allocator_core (
   input wire logic clock,
   input wire logic reset,
   ffea_req_if.sink   req_ch,
   ffea_rsp_if.source rsp_ch,
   ffea_csr_if.sink   csr_ch
);
   import ffea_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_write;
   logic     csr_ready;

   // configuration is taken between items
   assign csr_ch.ready = csr_ready;
   assign csr_write    = csr_ch.valid && csr_ready;

   ffea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .csr_write (csr_write),
      .stat      (stat),
      .req_ready (req_ch.ready),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   ffea_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_write       (csr_write),
      .csr_data        (csr_ch.data),
      .req_op          (req_ch.op),
      .req_start_index (req_ch.start_index),
      .req_block_count (req_ch.block_count),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_alloc_start (rsp_ch.alloc_start),
      .stat            (stat)
   );

endmodule
`default_nettype wire

// ----- design/ffea_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffea_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              csr_write,
   input  wire ffea_pkg::stat_type stat,
   output logic                   req_ready,
   output logic                   csr_ready,
   output ffea_pkg::cmd_type      cmd
);
   import ffea_pkg::*;

   state_type state_ff, state_in;

   // take a size write only between items
   assign csr_ready = (state_ff == S_IDLE);

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.init       = 1'b0;
      cmd.load       = 1'b0;
      cmd.rd_sel     = RD_NONE;
      cmd.wr_sel     = WR_NONE;
      cmd.idx_op     = IDX_HOLD;
      cmd.save_prev  = 1'b0;
      cmd.save_p     = 1'b0;
      cmd.cnt_inc    = 1'b0;
      cmd.cnt_dec    = 1'b0;
      cmd.res_set    = 1'b0;
      cmd.res_status = ST_OK;
      cmd.res_grant  = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !stat.out_busy && !csr_write;
            if (req_valid && !stat.out_busy && !csr_write) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.op_free) begin
               if (stat.n_zero) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_NO_SPACE;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_A_RD;
               end
            end else if (stat.free_skip) begin
               cmd.res_set = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_F_RD;
            end
         end
         S_A_RD: begin
            if (stat.idx_lt_cnt) begin
               cmd.rd_sel = RD_IDX;
               state_in   = S_A_EVAL;
            end else begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NO_SPACE;
               state_in       = S_IDLE;
            end
         end
         S_A_EVAL: begin
            if (stat.fits) begin
               cmd.res_set   = 1'b1;
               cmd.res_grant = 1'b1;
               if (stat.exact) begin
                  state_in = S_R_RD;
               end else begin
                  cmd.wr_sel = WR_TRIM;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_A_RD;
            end
         end
         // close the gap at idx, one entry per read and write step
         S_R_RD: begin
            if (stat.idx_p1_lt_cnt) begin
               cmd.rd_sel = RD_IDX_P1;
               state_in   = S_R_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_R_WR: begin
            cmd.wr_sel = WR_COPY;
            cmd.idx_op = IDX_INC;
            state_in   = S_R_RD;
         end
         S_F_RD: begin
            if (stat.idx_lt_cnt) begin
               cmd.rd_sel = RD_IDX;
               state_in   = S_F_EVAL;
            end else begin
               state_in = S_F_DEC;
            end
         end
         S_F_EVAL: begin
            if (stat.below) begin
               cmd.save_prev = 1'b1;
               cmd.idx_op    = IDX_INC;
               state_in      = S_F_RD;
            end else begin
               state_in = S_F_DEC;
            end
         end
         S_F_DEC: begin
            cmd.res_set = 1'b1;
            if (stat.lo && stat.hi) begin
               cmd.wr_sel = WR_MERGE_BOTH;
               state_in   = S_R_RD;
            end else if (stat.lo) begin
               cmd.wr_sel = WR_MERGE_LO;
               state_in   = S_IDLE;
            end else if (stat.hi) begin
               cmd.wr_sel = WR_MERGE_HI;
               state_in   = S_IDLE;
            end else if (stat.full) begin
               cmd.res_status = ST_TABLE_FULL;
               state_in       = S_IDLE;
            end else begin
               cmd.save_p = 1'b1;
               cmd.idx_op = IDX_CNT;
               state_in   = S_I_RD;
            end
         end
         // open a gap at p, top entry first
         S_I_RD: begin
            if (stat.idx_gt_p) begin
               cmd.rd_sel = RD_IDX_M1;
               state_in   = S_I_WR;
            end else begin
               cmd.wr_sel  = WR_INSERT;
               cmd.cnt_inc = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_I_WR: begin
            cmd.wr_sel = WR_COPY;
            cmd.idx_op = IDX_DEC;
            state_in   = S_I_RD;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      // a size write restarts the table
      if (csr_write) begin
         state_in = S_INIT;
      end
   end

endmodule
`default_nettype wire

// ----- design/ffea_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffea_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ffea_pkg::cmd_type cmd,
   input  wire logic              csr_write,
   input  wire logic [8:0]        csr_data,
   input  wire logic              req_op,
   input  wire logic [7:0]        req_start_index,
   input  wire logic [8:0]        req_block_count,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_alloc_start,
   output ffea_pkg::stat_type     stat
);
   import ffea_pkg::*;

   logic [15:0]       ext_mem [MAX_EXTENTS];
   logic [15:0]       rd_data_ff;
   logic [8:0]        mem_size_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  p_ff;
   logic              op_ff;
   logic [7:0]        s_ff;
   logic [8:0]        n_ff;
   logic [7:0]        prev_first_ff, prev_last_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [7:0]        rsp_start_ff;

   logic [7:0]        cur_first, cur_last;
   logic [8:0]        sz, len;
   logic [9:0]        run_end;
   logic [7:0]        e;
   logic [CNT_W-1:0]  idx_p1, idx_m1;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [15:0]       wr_data;

   assign cur_first = rd_data_ff[15:8];
   assign cur_last  = rd_data_ff[7:0];
   assign idx_p1    = idx_ff + 1'b1;
   assign idx_m1    = idx_ff - 1'b1;

   // clamp pool size and cut the freed run at the pool end
   assign sz      = (mem_size_ff > 9'(POOL_BLOCKS)) ? 9'(POOL_BLOCKS) : mem_size_ff;
   assign len     = {1'b0, cur_last} - {1'b0, cur_first} + 9'd1;
   assign run_end = {2'b00, s_ff} + {1'b0, n_ff} - 10'd1;
   assign e       = (run_end > {1'b0, sz - 9'd1}) ? 8'(sz - 9'd1) : run_end[7:0];

   // status toward the controller
   always_comb begin
      stat.op_free       = op_ff;
      stat.n_zero        = (n_ff == 9'd0);
      stat.free_skip     = (n_ff == 9'd0) || ({1'b0, s_ff} >= sz);
      stat.idx_lt_cnt    = (idx_ff < count_ff);
      stat.idx_p1_lt_cnt = ({1'b0, idx_ff} + 1'b1) < {1'b0, count_ff};
      stat.idx_gt_p      = (idx_ff > p_ff);
      stat.fits          = (len >= n_ff);
      stat.exact         = (len == n_ff);
      stat.below         = (cur_first < s_ff);
      stat.lo            = (idx_ff != '0) && (({1'b0, prev_last_ff} + 9'd1) == {1'b0, s_ff});
      stat.hi            = (idx_ff < count_ff) && ({1'b0, cur_first} == ({1'b0, e} + 9'd1));
      stat.full          = (count_ff >= CNT_W'(MAX_EXTENTS));
      stat.out_busy      = rsp_valid_ff && !rsp_ready;
   end

   // select read address
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = idx_ff[ADDR_W-1:0];
      case (cmd.rd_sel)
         RD_NONE:   rd_en = 1'b0;
         RD_IDX:    rd_addr = idx_ff[ADDR_W-1:0];
         RD_IDX_P1: rd_addr = idx_p1[ADDR_W-1:0];
         RD_IDX_M1: rd_addr = idx_m1[ADDR_W-1:0];
         default:   rd_en = 1'b0;
      endcase
   end

   // select write address and data
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff[ADDR_W-1:0];
      wr_data = rd_data_ff;
      if (cmd.init) begin
         wr_addr = '0;
         wr_data = {8'd0, 8'(sz - 9'd1)};
      end else begin
         case (cmd.wr_sel)
            WR_NONE: wr_en = 1'b0;
            WR_TRIM: wr_data = {cur_first + n_ff[7:0], cur_last};
            WR_COPY: wr_data = rd_data_ff;
            WR_MERGE_BOTH: begin
               wr_addr = idx_m1[ADDR_W-1:0];
               wr_data = {prev_first_ff, cur_last};
            end
            WR_MERGE_LO: begin
               wr_addr = idx_m1[ADDR_W-1:0];
               wr_data = {prev_first_ff, e};
            end
            WR_MERGE_HI: wr_data = {s_ff, cur_last};
            WR_INSERT:   wr_data = {s_ff, e};
            default:     wr_en = 1'b0;
         endcase
      end
   end

   // extent table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ext_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ext_mem[rd_addr];
      end
   end

   // advance the index and extent count
   always_comb begin
      idx_in = idx_ff;
      case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_INC:  idx_in = idx_p1;
         IDX_DEC:  idx_in = idx_m1;
         IDX_CNT:  idx_in = count_ff;
         default:  idx_in = idx_ff;
      endcase
      if (cmd.load) begin
         idx_in = '0;
      end
      count_in = count_ff;
      if (cmd.init) begin
         count_in = (sz != 9'd0) ? CNT_W'(1) : '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff  <= 9'(POOL_BLOCKS);
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            mem_size_ff <= csr_data;
         end
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.res_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         s_ff  <= req_start_index;
         n_ff  <= req_block_count;
      end
      if (cmd.save_prev) begin
         prev_first_ff <= cur_first;
         prev_last_ff  <= cur_last;
      end
      if (cmd.save_p) begin
         p_ff <= idx_ff;
      end
      if (cmd.res_set) begin
         rsp_status_ff <= cmd.res_status;
         rsp_start_ff  <= cmd.res_grant ? cur_first : 8'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_alloc_start = rsp_start_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EXTENTS))
      else $error("extent count above table depth");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == WR_INSERT) |-> !stat.full)
      else $error("insert into a full table");
   a_count_inc: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_inc && !cmd.init && !csr_write) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("extent count did not advance on insert");

endmodule
`default_nettype wire
